FILE: src/fstap_pkg.sv
// Shared types and constants for the footswitch tap-tempo controller.
// No dependencies; used by the channel interfaces, fstap_step and the top level.

package fstap_pkg;

	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_HOLD       = 2'd1,
		REG_TAP_WINDOW = 2'd2
	} reg_idx_t;

	localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [15:0] HOLD_RESET       = 16'd1000;
	localparam logic [15:0] TAP_WINDOW_RESET = 16'd3000;

	typedef enum logic [1:0] {
		PH_OPEN   = 2'd0,
		PH_PRESS  = 2'd1,
		PH_HOLD   = 2'd2,
		PH_HOLD_B = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_OPEN    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_HOLD    = 3'd2,
		EV_HOLD_B  = 3'd3,
		EV_TOGGLE  = 3'd4,
		EV_TEMPO   = 3'd5,
		EV_TEMPO_B = 3'd6
	} evt_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] hold_ms;
		logic [15:0] tap_window_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        switch_closed;
		logic        edge_seen;
		logic [31:0] edge_time;
		logic        begin_tempo_b;
		logic        tempo_taken;
	} tick_t;

	typedef struct packed {
		evt_t        event_code;
		logic [15:0] tempo_ms;
		logic        tempo_ready;
	} report_t;

	typedef struct packed {
		phase_t phase;
		logic   edge_pending;
		logic   tempo_flag;
	} ctl_t;

endpackage

FILE: src/fstap_if.sv
// Valid/ready channel interfaces for poll ticks and reports.
// Depends on fstap_pkg for the payload types.

interface fstap_tick_if;
	import fstap_pkg::*;

	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fstap_report_if;
	import fstap_pkg::*;

	logic    valid;
	logic    ready;
	report_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/footswitch_tap_tempo_fsm.sv
// Footswitch tap-tempo controller: debounce, press/hold, tap capture, tempo report.
// A tick is registered in the input stage; its report is then registered in the output stage.
// Throughput: one tick per cycle while the report side is ready, set by the single register stage on each side.
// Reset: phase open, time mark, edge stamp and tempo cleared; registers at defaults.
// Depends on fstap_pkg, fstap_if and fstap_step.

module footswitch_tap_tempo_fsm #(
	parameter int TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [fstap_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [15:0]                         wr_data,
	fstap_tick_if.sink                          tick,
	fstap_report_if.source                      report
);
	import fstap_pkg::*;

	cfg_t                 cfg_q;
	logic                 valid_s1;
	tick_t                item_s1;
	logic                 out_valid_q;
	report_t              out_q;
	ctl_t                 ctl_q;
	logic [TIME_BITS-1:0] mark_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [15:0]          tempo_q;
	ctl_t                 ctl_d;
	logic [TIME_BITS-1:0] mark_d;
	logic [TIME_BITS-1:0] stamp_d;
	logic [15:0]          tempo_d;
	report_t              res;
	logic                 advance;

	assign advance     = valid_s1 && (!out_valid_q || report.ready);
	assign tick.ready  = !valid_s1 || advance;
	assign report.valid = out_valid_q;
	assign report.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RESET;
			cfg_q.hold_ms       <= HOLD_RESET;
			cfg_q.tap_window_ms <= TAP_WINDOW_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= wr_data;
				REG_HOLD:       cfg_q.hold_ms       <= wr_data;
				REG_TAP_WINDOW: cfg_q.tap_window_ms <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// hold the tick until the step logic can deliver its report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (tick.ready)
			valid_s1 <= tick.valid;
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready)
			item_s1 <= tick.data;
	end

	fstap_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.cfg       (cfg_q),
		.item      (item_s1),
		.ctl_cur   (ctl_q),
		.mark_cur  (mark_q),
		.stamp_cur (stamp_q),
		.tempo_cur (tempo_q),
		.ctl_nxt   (ctl_d),
		.mark_nxt  (mark_d),
		.stamp_nxt (stamp_d),
		.tempo_nxt (tempo_d),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase        <= PH_OPEN;
			ctl_q.edge_pending <= 1'b0;
			ctl_q.tempo_flag   <= 1'b0;
			mark_q             <= '0;
			stamp_q            <= '0;
			tempo_q            <= '0;
		end else if (advance) begin
			ctl_q   <= ctl_d;
			mark_q  <= mark_d;
			stamp_q <= stamp_d;
			tempo_q <= tempo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (report.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	a_advance_loads_report: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("report not loaded after step");

	a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(ctl_q) && $stable(mark_q) && $stable(tempo_q)))
		else $error("state changed without a step");

	a_no_flag_outside_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase == PH_OPEN || ctl_q.phase == PH_PRESS) |-> !ctl_q.tempo_flag)
		else $error("tempo flag set outside tap entry");

	a_toggle_returns_open: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.event_code == EV_TOGGLE) |=> ctl_q.phase == PH_OPEN)
		else $error("toggle did not return to open");

endmodule

FILE: src/fstap_step.sv
// Next-state and report logic for one poll tick of the tap-tempo controller.
// Depends on fstap_pkg; instantiated by footswitch_tap_tempo_fsm.

module fstap_step #(
	parameter int TIME_BITS = 32
) (
	input  fstap_pkg::cfg_t    cfg,
	input  fstap_pkg::tick_t   item,
	input  fstap_pkg::ctl_t    ctl_cur,
	input  logic [TIME_BITS-1:0] mark_cur,
	input  logic [TIME_BITS-1:0] stamp_cur,
	input  logic [15:0]        tempo_cur,
	output fstap_pkg::ctl_t    ctl_nxt,
	output logic [TIME_BITS-1:0] mark_nxt,
	output logic [TIME_BITS-1:0] stamp_nxt,
	output logic [15:0]        tempo_nxt,
	output fstap_pkg::report_t res
);
	import fstap_pkg::*;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] etime_t;
	logic [TIME_BITS-1:0] mark_a;
	logic [TIME_BITS-1:0] gap_e;
	logic [TIME_BITS-1:0] gap_n;
	logic [TIME_BITS-1:0] deb_t;
	logic [TIME_BITS-1:0] hold_t;
	logic [TIME_BITS-1:0] win_t;
	phase_t               ph_a;
	logic                 pend_a;
	logic                 flag_a;
	evt_t                 code;

	assign now_t   = TIME_BITS'(item.now_ms);
	assign etime_t = TIME_BITS'(item.edge_time);
	assign deb_t   = TIME_BITS'(cfg.debounce_ms);
	assign hold_t  = TIME_BITS'(cfg.hold_ms);
	assign win_t   = TIME_BITS'(cfg.tap_window_ms);

	always_comb begin
		pend_a    = ctl_cur.edge_pending;
		stamp_nxt = stamp_cur;
		if (item.edge_seen && item.switch_closed) begin
			pend_a    = 1'b1;
			stamp_nxt = etime_t;
		end
		ph_a   = ctl_cur.phase;
		mark_a = mark_cur;
		flag_a = ctl_cur.tempo_flag;
		if (item.begin_tempo_b) begin
			ph_a   = PH_HOLD_B;
			mark_a = now_t;
			flag_a = 1'b0;
		end
		if (item.tempo_taken)
			flag_a = 1'b0;
	end

	assign gap_e = stamp_nxt - mark_a;
	assign gap_n = now_t - mark_a;

	always_comb begin
		ctl_nxt.phase        = ph_a;
		ctl_nxt.edge_pending = pend_a;
		ctl_nxt.tempo_flag   = flag_a;
		mark_nxt             = mark_a;
		tempo_nxt            = tempo_cur;
		code                 = EV_OPEN;
		unique case (ph_a)
			PH_OPEN: begin
				if (pend_a) begin
					ctl_nxt.edge_pending = 1'b0;
					if (gap_e >= deb_t) begin
						mark_nxt      = stamp_nxt;
						ctl_nxt.phase = PH_PRESS;
						code          = EV_PRESS;
					end
				end
			end
			PH_PRESS: begin
				code = EV_PRESS;
				if (item.switch_closed) begin
					if (gap_n >= hold_t) begin
						ctl_nxt.phase = PH_HOLD;
						mark_nxt      = now_t;
						tempo_nxt     = '0;
						code          = EV_HOLD;
					end
				end else if (gap_n > deb_t) begin
					ctl_nxt.phase        = PH_OPEN;
					ctl_nxt.edge_pending = 1'b0;
					ctl_nxt.tempo_flag   = 1'b0;
					mark_nxt             = now_t;
					code                 = EV_TOGGLE;
				end
			end
			PH_HOLD, PH_HOLD_B: begin
				code = (ph_a == PH_HOLD) ? EV_HOLD : EV_HOLD_B;
				if (pend_a) begin
					ctl_nxt.edge_pending = 1'b0;
					if (gap_e >= deb_t && gap_e < win_t) begin
						mark_nxt           = stamp_nxt;
						tempo_nxt          = gap_e[15:0];
						ctl_nxt.tempo_flag = 1'b1;
					end
				end else if (gap_n > win_t && tempo_cur != 16'd0) begin
					ctl_nxt.phase        = PH_OPEN;
					ctl_nxt.edge_pending = 1'b0;
					ctl_nxt.tempo_flag   = 1'b0;
					mark_nxt             = now_t;
					code = (ph_a == PH_HOLD) ? EV_TEMPO : EV_TEMPO_B;
				end
			end
			default: begin
				code = EV_OPEN;
			end
		endcase
	end

	assign res.event_code  = code;
	assign res.tempo_ms    = tempo_nxt;
	assign res.tempo_ready = ctl_nxt.tempo_flag;

endmodule
